>>> rtl/core/tfm_pkg.sv
`default_nettype none
package tfm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [2:0] STAT_RECEIVED  = 3'd0;
  localparam logic [2:0] STAT_DROPS     = 3'd1;
  localparam logic [2:0] STAT_TIMEOUTS  = 3'd2;
  localparam logic [2:0] STAT_ERRORS    = 3'd3;
  localparam logic [2:0] STAT_INVALID   = 3'd4;
  localparam logic [2:0] STAT_POOL      = 3'd5;
  localparam logic [2:0] STAT_TRIGFAIL  = 3'd6;
  localparam logic [2:0] STAT_UNMATCHED = 3'd7;
  localparam logic [3:0] STAT_LAST_FRAME = 4'd8;
  localparam logic [3:0] STAT_LAST_TS    = 4'd9;

  typedef enum logic [2:0] {
    CMD_TRIGGER   = 3'd0,
    CMD_CANCEL    = 3'd1,
    CMD_FRAME     = 3'd2,
    CMD_TIMEOUT   = 3'd3,
    CMD_ERROR     = 3'd4,
    CMD_READ_STAT = 3'd5,
    CMD_CLEAR     = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    STS_DONE           = 3'd0,
    STS_QUEUE_FULL     = 3'd1,
    STS_NO_CANCEL      = 3'd2,
    STS_ACCEPTED       = 3'd3,
    STS_INVALID        = 3'd4,
    STS_POOL_EXHAUSTED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_PIXEL_FORMAT  = 2'd2,
    REG_SW_TRIGGER    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    BK_ISSUE = 1'b0,
    BK_MATCH = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] pix_fmt;
    logic        sw_trigger;
  } cfg_t;

  // decoded word passed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] value;
    logic [31:0] dropped;
    logic        frame_bad;
    logic        pool_available;
    logic [47:0] timestamp;
    logic [3:0]  stat_index;
  } op_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] matched_cycle;
    logic        trigger_matched;
    logic [31:0] dropped_frames;
    logic [47:0] stat_value;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/tfm_front.sv
`default_nettype none
module tfm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire tfm_pkg::cfg_t cfg,
  input  wire logic [2:0]    command,
  input  wire logic [31:0]   trig_cycle,
  input  wire logic [31:0]   frame_seq,
  input  wire logic [15:0]   frame_width_in,
  input  wire logic [15:0]   frame_height_in,
  input  wire logic [31:0]   pix_fmt,
  input  wire logic [31:0]   byte_count,
  input  wire logic          data_present,
  input  wire logic          pool_available,
  input  wire logic [47:0]   cam_stamp,
  input  wire logic [3:0]    stat_index,
  output tfm_pkg::op_t       op
);

  logic [31:0] previous_frame;
  logic [31:0] area;
  logic [32:0] prev_plus;
  logic        gap;
  tfm_pkg::cmd_t cmd;

  assign cmd       = tfm_pkg::cmd_t'(command);
  assign area      = 32'(frame_width_in) * 32'(frame_height_in);
  assign prev_plus = {1'b0, previous_frame} + 33'd1;
  assign gap       = (previous_frame != 32'd0) && ({1'b0, frame_seq} > prev_plus);

  always_comb begin
    op.cmd            = cmd;
    op.value          = (cmd == tfm_pkg::CMD_FRAME) ? frame_seq : trig_cycle;
    op.dropped        = gap ? (frame_seq - previous_frame - 32'd1) : 32'd0;
    op.frame_bad      = (frame_width_in != cfg.frame_width) ||
                        (frame_height_in != cfg.frame_height) ||
                        (pix_fmt != cfg.pix_fmt) ||
                        (byte_count < area) || !data_present;
    op.pool_available = pool_available;
    op.timestamp      = cam_stamp;
    op.stat_index     = stat_index;
  end

  // frame number history tracked here so drops are known at entry
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_frame <= 32'd0;
    end else if (accept) begin
      if (cmd == tfm_pkg::CMD_FRAME) begin
        previous_frame <= frame_seq;
      end else if (cmd == tfm_pkg::CMD_CLEAR) begin
        previous_frame <= 32'd0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tfm_cmd_queue.sv
`default_nettype none
module tfm_cmd_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire tfm_pkg::op_t wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output tfm_pkg::op_t      rd_data,
  output logic              empty
);

  tfm_pkg::op_t entries [tfm_pkg::CQ_DEPTH];
  logic [tfm_pkg::CQ_PTR_W-1:0] wr_ptr;
  logic [tfm_pkg::CQ_PTR_W-1:0] rd_ptr;
  logic [tfm_pkg::CQ_CNT_W-1:0] count;
  logic do_wr;
  logic do_rd;

  assign full    = (count == tfm_pkg::CQ_CNT_W'(tfm_pkg::CQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tfm_back.sv
`default_nettype none
module tfm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tfm_pkg::cfg_t cfg,
  input  wire tfm_pkg::op_t  op,
  input  wire logic          op_empty,
  output logic               op_pop,
  output tfm_pkg::res_t      res_out,
  output logic               res_empty,
  input  wire logic          res_pop
);

  localparam int CQ = tfm_pkg::QUEUE_DEPTH;
  localparam int PW = tfm_pkg::PTR_W;
  localparam int CW = tfm_pkg::CNT_W;
  localparam int SW = tfm_pkg::SUM_W;

  function automatic logic [PW-1:0] wrap_ptr(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(CQ)) ? (s - SW'(CQ)) : s;
    return r[PW-1:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : (v + 32'd1);
  endfunction

  // trigger cycle store
  logic [31:0] mem [CQ];
  logic [31:0] rdata;
  logic        mem_we;
  logic [PW-1:0] mem_wa;
  logic        mem_re;
  logic [PW-1:0] mem_ra;

  tfm_pkg::back_state_t state;
  tfm_pkg::back_state_t state_next;
  logic [PW-1:0] head;
  logic [PW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [31:0] counters [8];
  logic [31:0] counters_next [8];
  logic [31:0] last_frame_seen;
  logic [31:0] last_frame_seen_next;
  logic [47:0] last_timestamp;
  logic [47:0] last_timestamp_next;

  // result queue
  tfm_pkg::res_t res_q [2];
  logic        rq_wr;
  logic        rq_rd;
  logic [1:0]  rq_count;
  logic        rq_push;
  logic        rq_pop_ok;
  logic        room;
  tfm_pkg::res_t res;

  logic [CW-1:0] discard;
  logic [PW-1:0] head_skip;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_inc;
  logic [32:0]   drop_sum;

  assign room      = (rq_count != 2'd2);
  assign rq_pop_ok = res_pop && !res_empty;
  assign res_empty = (rq_count == 2'd0);
  assign res_out   = res_q[rq_rd];

  assign discard   = (op.dropped < 32'(count)) ? op.dropped[CW-1:0] : count;
  assign head_skip = wrap_ptr(SW'(head) + SW'(discard));
  assign tail      = wrap_ptr(SW'(head) + SW'(count));
  assign head_inc  = (head == PW'(CQ - 1)) ? '0 : (head + 1'b1);
  assign drop_sum  = {1'b0, counters[tfm_pkg::STAT_DROPS]} + {1'b0, op.dropped};
  assign mem_wa    = tail;

  always_comb begin
    state_next           = state;
    head_next            = head;
    count_next           = count;
    counters_next        = counters;
    last_frame_seen_next = last_frame_seen;
    last_timestamp_next  = last_timestamp;
    op_pop               = 1'b0;
    rq_push              = 1'b0;
    mem_we               = 1'b0;
    mem_re               = 1'b0;
    mem_ra               = head_skip;
    res                  = '0;
    res.status           = tfm_pkg::STS_DONE;

    case (state)
      tfm_pkg::BK_ISSUE: begin
        if (!op_empty) begin
          if (op.cmd == tfm_pkg::CMD_FRAME) begin
            // discard dropped triggers and fetch the next one
            head_next  = head_skip;
            count_next = count - discard;
            counters_next[tfm_pkg::STAT_DROPS] = drop_sum[32] ? 32'hFFFF_FFFF
                                                              : drop_sum[31:0];
            mem_re     = 1'b1;
            state_next = tfm_pkg::BK_MATCH;
          end else if (room) begin
            op_pop  = 1'b1;
            rq_push = 1'b1;
            case (op.cmd)
              tfm_pkg::CMD_TRIGGER: begin
                if (count == CW'(CQ)) begin
                  counters_next[tfm_pkg::STAT_TRIGFAIL] =
                    sat_inc(counters[tfm_pkg::STAT_TRIGFAIL]);
                  res.status = tfm_pkg::STS_QUEUE_FULL;
                end else begin
                  mem_we     = 1'b1;
                  count_next = count + 1'b1;
                end
              end
              tfm_pkg::CMD_CANCEL: begin
                counters_next[tfm_pkg::STAT_TRIGFAIL] =
                  sat_inc(counters[tfm_pkg::STAT_TRIGFAIL]);
                if (count == '0) begin
                  res.status = tfm_pkg::STS_NO_CANCEL;
                end else begin
                  count_next = count - 1'b1;
                end
              end
              tfm_pkg::CMD_TIMEOUT: begin
                counters_next[tfm_pkg::STAT_TIMEOUTS] =
                  sat_inc(counters[tfm_pkg::STAT_TIMEOUTS]);
              end
              tfm_pkg::CMD_ERROR: begin
                counters_next[tfm_pkg::STAT_ERRORS] =
                  sat_inc(counters[tfm_pkg::STAT_ERRORS]);
              end
              tfm_pkg::CMD_READ_STAT: begin
                if (!op.stat_index[3]) begin
                  res.stat_value = 48'(counters[op.stat_index[2:0]]);
                end else if (op.stat_index == tfm_pkg::STAT_LAST_FRAME) begin
                  res.stat_value = 48'(last_frame_seen);
                end else if (op.stat_index == tfm_pkg::STAT_LAST_TS) begin
                  res.stat_value = last_timestamp;
                end
              end
              tfm_pkg::CMD_CLEAR: begin
                head_next            = '0;
                count_next           = '0;
                last_frame_seen_next = '0;
                last_timestamp_next  = '0;
                for (int i = 0; i < 8; i++) begin
                  counters_next[i] = '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      tfm_pkg::BK_MATCH: begin
        if (room) begin
          op_pop             = 1'b1;
          rq_push            = 1'b1;
          res.dropped_frames = op.dropped;
          state_next         = tfm_pkg::BK_ISSUE;
          if (cfg.sw_trigger) begin
            if (count == '0) begin
              counters_next[tfm_pkg::STAT_UNMATCHED] =
                sat_inc(counters[tfm_pkg::STAT_UNMATCHED]);
            end else begin
              res.matched_cycle   = rdata;
              res.trigger_matched = 1'b1;
              head_next           = head_inc;
              count_next          = count - 1'b1;
            end
          end
          if (op.frame_bad) begin
            counters_next[tfm_pkg::STAT_INVALID] =
              sat_inc(counters[tfm_pkg::STAT_INVALID]);
            res.status = tfm_pkg::STS_INVALID;
          end else if (!op.pool_available) begin
            counters_next[tfm_pkg::STAT_POOL] = sat_inc(counters[tfm_pkg::STAT_POOL]);
            res.status = tfm_pkg::STS_POOL_EXHAUSTED;
          end else begin
            counters_next[tfm_pkg::STAT_RECEIVED] =
              sat_inc(counters[tfm_pkg::STAT_RECEIVED]);
            last_frame_seen_next = op.value;
            last_timestamp_next  = op.timestamp;
            res.status           = tfm_pkg::STS_ACCEPTED;
          end
        end
      end
      default: begin
        state_next = tfm_pkg::BK_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= op.value;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tfm_pkg::BK_ISSUE;
      head            <= '0;
      count           <= '0;
      last_frame_seen <= '0;
      last_timestamp  <= '0;
      for (int i = 0; i < 8; i++) begin
        counters[i] <= '0;
      end
    end else begin
      state           <= state_next;
      head            <= head_next;
      count           <= count_next;
      last_frame_seen <= last_frame_seen_next;
      last_timestamp  <= last_timestamp_next;
      counters        <= counters_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      res_q[rq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (rq_push) begin
        rq_wr <= ~rq_wr;
      end
      if (rq_pop_ok) begin
        rq_rd <= ~rq_rd;
      end
      if (rq_push && !rq_pop_ok) begin
        rq_count <= rq_count + 2'd1;
      end else if (rq_pop_ok && !rq_push) begin
        rq_count <= rq_count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/trigger_frame_matcher_unit.sv
`default_nettype none
// Trigger-to-frame matcher for one camera. Words enter through push/full and
// results leave through empty/pop, one result per word, in order. The front
// takes one word per cycle while its four-word command queue has room, and
// works out frame drops and the frame checks on entry. The back executes one
// word per cycle while its two-word output queue has room; a frame passes an issue
// and a match state, its matching trigger cycle read from the trigger queue
// memory's registered read port. The user must write configuration registers
// only while the block is idle, not enforced here; they take effect for the next word.
module trigger_frame_matcher_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] trig_cycle,
  input  wire logic [31:0] frame_seq,
  input  wire logic [15:0] frame_width_in,
  input  wire logic [15:0] frame_height_in,
  input  wire logic [31:0] pix_fmt,
  input  wire logic [31:0] byte_count,
  input  wire logic        data_present,
  input  wire logic        pool_available,
  input  wire logic [47:0] cam_stamp,
  input  wire logic [3:0]  stat_index,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status,
  output logic [31:0]      matched_cycle,
  output logic             trigger_matched,
  output logic [31:0]      dropped_frames,
  output logic [47:0]      stat_value
);

  tfm_pkg::cfg_t cfg;
  tfm_pkg::op_t  front_op;
  tfm_pkg::op_t  back_op;
  tfm_pkg::res_t res;
  logic accept;
  logic cq_empty;
  logic cq_pop;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 16'd1920;
      cfg.frame_height <= 16'd1080;
      cfg.pix_fmt      <= 32'h0108_0009;
      cfg.sw_trigger   <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        tfm_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[15:0];
        tfm_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[15:0];
        tfm_pkg::REG_PIXEL_FORMAT: cfg.pix_fmt      <= cfg_data;
        tfm_pkg::REG_SW_TRIGGER:   cfg.sw_trigger   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tfm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .cfg              (cfg),
    .command          (command),
    .trig_cycle       (trig_cycle),
    .frame_seq        (frame_seq),
    .frame_width_in   (frame_width_in),
    .frame_height_in  (frame_height_in),
    .pix_fmt          (pix_fmt),
    .byte_count       (byte_count),
    .data_present     (data_present),
    .pool_available   (pool_available),
    .cam_stamp        (cam_stamp),
    .stat_index       (stat_index),
    .op               (front_op)
  );

  tfm_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_op),
    .full    (full),
    .rd_en   (cq_pop),
    .rd_data (back_op),
    .empty   (cq_empty)
  );

  tfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op        (back_op),
    .op_empty  (cq_empty),
    .op_pop    (cq_pop),
    .res_out   (res),
    .res_empty (empty),
    .res_pop   (pop)
  );

  assign status          = res.status;
  assign matched_cycle   = res.matched_cycle;
  assign trigger_matched = res.trigger_matched;
  assign dropped_frames  = res.dropped_frames;
  assign stat_value      = res.stat_value;

endmodule
`default_nettype wire
